### hdl/scb_pkg.sv
// scb_pkg: constants, period table and reply codes of the serial blink-rate block
// used by the channel interfaces and by serial_controlled_blink_rate
`default_nettype none

package scb_pkg;

  localparam int unsigned NUM_PERIODS = 7;   // legal range 2 to 8
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned CNT_W       = 15;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned BEAT_W      = 2;

  localparam logic [IDX_W-1:0] TOP_INDEX = IDX_W'(NUM_PERIODS - 1);

  localparam logic [CNT_W-1:0] PERIOD_TABLE [8] = '{
    15'd16000, 15'd8000, 15'd5333, 15'd4000,
    15'd2666,  15'd2000, 15'd1600, 15'd1333
  };

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_K     = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  localparam logic [BEAT_W-1:0] BEAT_FIRST  = 2'd0;
  localparam logic [BEAT_W-1:0] BEAT_SECOND = 2'd1;

  localparam logic CMD_TICK = 1'b0;

  typedef enum logic [1:0] {
    REPLY_NONE,
    REPLY_QUERY,
    REPLY_OK
  } reply_e;

endpackage

`default_nettype wire

### hdl/scb_in_if.sv
// scb_in_if: input channel, a timer tick or a received character per beat
// depends on scb_pkg for the field widths
`default_nettype none

interface scb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [scb_pkg::CHAR_W-1:0] ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink   (input valid, input cmd, input ch, output ready);
endinterface

`default_nettype wire

### hdl/scb_out_if.sv
// scb_out_if: result channel, one reply character slot and the led level per beat
// depends on scb_pkg for the field widths
`default_nettype none

interface scb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       led_level;
  logic                       char_valid;
  logic [scb_pkg::CHAR_W-1:0] tx_char;
  logic                       last;

  modport source (output valid, output led_level, output char_valid, output tx_char,
                  output last, input ready);
  modport sink   (input valid, input led_level, input char_valid, input tx_char,
                  input last, output ready);
endinterface

`default_nettype wire

### hdl/serial_controlled_blink_rate.sv
// serial_controlled_blink_rate: blink timer with a serial command interpreter
// depends on scb_pkg, scb_in_if and scb_out_if
//
//   channel | dir | beat payload
//   in_i    | in  | cmd, ch
//   out_o   | out | led_level, char_valid, tx_char, last
//
// blinker state is updated in the cycle an input beat is taken; the reply is
// held in an output register and sent by a small beat sequencer, one beat a cycle
// while out_o.ready is high; a tick, cr or lf gives one beat with no character,
// an unknown character gives '?' then lf, and '+', '-' or '0' give 'O', 'K', lf
// the next input is taken while the final reply beat is being taken
// reset: count 0, index 0, blinking on, led dark; a stalled reply beat holds
`default_nettype none

module serial_controlled_blink_rate (
  input  wire  clk_i,
  input  wire  rst_ni,
  scb_in_if.sink    in_i,
  scb_out_if.source out_o
);
  import scb_pkg::*;

  logic [CNT_W-1:0]  tick_count_q, tick_count_d;
  logic [IDX_W-1:0]  period_index_q, period_index_d;
  logic              blink_enabled_q, blink_enabled_d;
  logic              led_pin_q, led_pin_d;

  logic              out_valid_q;
  reply_e            reply_q, reply_d;
  logic [BEAT_W-1:0] beat_q;
  logic              led_out_q;

  logic              out_last;
  logic              in_accept;

  assign in_i.ready = !out_valid_q || (out_o.ready && out_last);
  assign in_accept  = in_i.valid && in_i.ready;

  // next blinker state and reply kind for the beat on the input
  always_comb begin
    tick_count_d    = tick_count_q;
    period_index_d  = period_index_q;
    blink_enabled_d = blink_enabled_q;
    led_pin_d       = led_pin_q;
    reply_d         = REPLY_NONE;
    if (in_i.cmd == CMD_TICK) begin
      if (blink_enabled_q) begin
        if (tick_count_q <= CNT_W'(1)) begin
          led_pin_d    = !led_pin_q;
          tick_count_d = PERIOD_TABLE[period_index_q];
        end else begin
          tick_count_d = tick_count_q - CNT_W'(1);
        end
      end
    end else begin
      case (in_i.ch)
        CH_PLUS: begin
          reply_d = REPLY_OK;
          if (!blink_enabled_q) begin
            blink_enabled_d = 1'b1;
            led_pin_d       = 1'b1;
          end
          if (period_index_q < TOP_INDEX) begin
            period_index_d = period_index_q + IDX_W'(1);
            tick_count_d   = PERIOD_TABLE[period_index_q + IDX_W'(1)];
          end
        end
        CH_MINUS: begin
          reply_d = REPLY_OK;
          if (!blink_enabled_q) begin
            blink_enabled_d = 1'b1;
            led_pin_d       = 1'b1;
          end
          if (period_index_q != '0) begin
            period_index_d = period_index_q - IDX_W'(1);
            tick_count_d   = PERIOD_TABLE[period_index_q - IDX_W'(1)];
          end
        end
        CH_ZERO: begin
          reply_d         = REPLY_OK;
          blink_enabled_d = 1'b0;
          led_pin_d       = 1'b0;
        end
        CH_LF, CH_CR: begin
          reply_d = REPLY_NONE;
        end
        default: begin
          reply_d = REPLY_QUERY;
        end
      endcase
    end
  end

  // reply beat decode
  always_comb begin
    out_o.char_valid = 1'b0;
    out_o.tx_char    = CH_NUL;
    out_last         = 1'b1;
    case (reply_q)
      REPLY_NONE: begin
        out_last = 1'b1;
      end
      REPLY_QUERY: begin
        out_o.char_valid = 1'b1;
        out_o.tx_char    = (beat_q == BEAT_FIRST) ? CH_QUERY : CH_LF;
        out_last         = (beat_q != BEAT_FIRST);
      end
      REPLY_OK: begin
        out_o.char_valid = 1'b1;
        case (beat_q)
          BEAT_FIRST: begin
            out_o.tx_char = CH_O;
            out_last      = 1'b0;
          end
          BEAT_SECOND: begin
            out_o.tx_char = CH_K;
            out_last      = 1'b0;
          end
          default: begin
            out_o.tx_char = CH_LF;
            out_last      = 1'b1;
          end
        endcase
      end
      default: begin
        out_last = 1'b1;
      end
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.last      = out_last;
  assign out_o.led_level = led_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q    <= '0;
      period_index_q  <= '0;
      blink_enabled_q <= 1'b1;
      led_pin_q       <= 1'b0;
      out_valid_q     <= 1'b0;
      reply_q         <= REPLY_NONE;
      beat_q          <= BEAT_FIRST;
    end else if (in_accept) begin
      tick_count_q    <= tick_count_d;
      period_index_q  <= period_index_d;
      blink_enabled_q <= blink_enabled_d;
      led_pin_q       <= led_pin_d;
      out_valid_q     <= 1'b1;
      reply_q         <= reply_d;
      beat_q          <= BEAT_FIRST;
    end else if (out_valid_q && out_o.ready) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
      end else begin
        beat_q <= beat_q + BEAT_W'(1);
      end
    end
  end

  // led level travels with the reply, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      led_out_q <= led_pin_d;
    end
  end

endmodule

`default_nettype wire
